>>> hw/rtl/cls_pkg.sv
// cls_pkg: shared constants, controller states and the command/status structs
// for the Cramer's-rule solver. No dependencies.
package cls_pkg;

  localparam int MaxSizeDef    = 4;
  localparam int EntryBitsDef  = 12;
  localparam int FracBits      = 16;
  localparam int CfgW          = 3;
  localparam int RowW          = 2;
  localparam int ColW          = 3;
  localparam int InEntryW      = 12;
  localparam int OutIdxW       = 2;
  localparam int SolW          = 64;
  localparam int DivSteps      = SolW + FracBits;
  localparam int DivCntW       = $clog2(DivSteps);
  localparam int STdataW       = 24;
  localparam int MTdataW       = 72;
  localparam logic [CfgW-1:0] SizeReset = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_NEXT,
    ST_DONE,
    ST_DIV,
    ST_EMIT,
    ST_SING
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic solve_start;
    logic prod_init;
    logic rd_issue;
    logic mul;
    logic acc_add;
    logic tuple_next;
    logic den_save;
    logic div_start;
    logic div_step;
    logic det_next;
    logic out_load_result;
    logic out_load_singular;
  } cls_cmd_t;

  typedef struct packed {
    logic tuple_valid;
    logic tuple_last;
    logic row_last;
    logic acc_zero;
    logic div_last;
    logic out_free;
    logic unknown_last;
    logic first_det;
  } cls_sts_t;

endpackage

>>> hw/rtl/cls_datapath.sv
// cls_datapath: entry store, permutation walk, product/accumulate, serial
// fixed-point divider and output register. Depends on cls_pkg.
module cls_datapath #(
  parameter int MAX_SIZE   = cls_pkg::MaxSizeDef,
  parameter int ENTRY_BITS = cls_pkg::EntryBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cls_pkg::cls_cmd_t           cmd_i,
  output cls_pkg::cls_sts_t           sts_o,
  input  logic                        cfg_valid_i,
  input  logic [cls_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [cls_pkg::STdataW-1:0] s_tdata_i,
  input  logic                        m_tready_i,
  output logic                        m_tvalid_o,
  output logic [cls_pkg::MTdataW-1:0] m_tdata_o,
  output logic                        m_tlast_o,
  output logic                        m_tuser_o
);
  import cls_pkg::*;

  localparam int IdxW   = $clog2(MAX_SIZE);
  localparam int SzW    = $clog2(MAX_SIZE + 1);
  localparam int Stride = MAX_SIZE + 1;
  localparam int Depth  = MAX_SIZE * Stride;
  localparam int AddrW  = $clog2(Depth);

  logic [CfgW-1:0]       size_q;
  logic [SzW-1:0]        n;
  logic [ENTRY_BITS-1:0] mem [Depth];
  logic [ENTRY_BITS-1:0] rdata_q;

  logic [IdxW-1:0]       dig_q [MAX_SIZE];
  logic [IdxW-1:0]       dig_d [MAX_SIZE];
  logic [IdxW-1:0]       row_q;
  logic [SzW-1:0]        j_q;
  logic signed [SolW-1:0] prod_q, acc_q, den_q;
  logic [SolW-1:0]       b_q, rem_q;
  logic [DivSteps-1:0]   dq_q;
  logic                  neg_q;
  logic [DivCntW-1:0]    cnt_q;

  logic                  out_valid_q, out_sing_q, out_last_q;
  logic [OutIdxW-1:0]    out_idx_q;
  logic [SolW-1:0]       out_val_q;

  logic [RowW-1:0]       in_row;
  logic [ColW-1:0]       in_col;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr, rd_addr;
  logic [IdxW-1:0]       dsel;
  logic                  collide, parity, t_last, carry;
  logic [SolW:0]         rem_sh, rem_diff;
  logic                  ge;
  logic                  sat;
  logic [SolW-1:0]       qmag;

  function automatic logic [SolW-1:0] abs64(input logic signed [SolW-1:0] v);
    abs64 = v[SolW-1] ? (SolW'(0) - SolW'(v)) : SolW'(v);
  endfunction

  always_comb begin
    if (int'(size_q) < 2) begin
      n = SzW'(2);
    end else if (int'(size_q) > MAX_SIZE) begin
      n = SzW'(MAX_SIZE);
    end else begin
      n = SzW'(size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // store: row-major, column MAX_SIZE of each row holds the rhs element
  assign in_row = s_tdata_i[RowW-1:0];
  assign in_col = s_tdata_i[RowW +: ColW];
  assign wr_en  = cmd_i.load && (int'(in_row) < MAX_SIZE) && (int'(in_col) <= int'(n));
  assign wr_addr = AddrW'(in_row) * AddrW'(Stride)
                 + ((int'(in_col) == int'(n)) ? AddrW'(MAX_SIZE) : AddrW'(in_col));

  assign dsel    = dig_q[row_q];
  assign rd_addr = AddrW'(row_q) * AddrW'(Stride)
                 + (((j_q != '0) && (int'(dsel) == int'(j_q) - 1)) ?
                    AddrW'(MAX_SIZE) : AddrW'(dsel));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= s_tdata_i[RowW + ColW +: ENTRY_BITS];
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // column tuple: distinctness, inversion parity, odometer step
  always_comb begin
    collide = 1'b0;
    parity  = 1'b0;
    t_last  = 1'b1;
    carry   = 1'b1;
    for (int r = 0; r < MAX_SIZE; r++) begin
      dig_d[r] = dig_q[r];
      if (r < int'(n)) begin
        if (int'(dig_q[r]) != int'(n) - 1) t_last = 1'b0;
        for (int s = r + 1; s < MAX_SIZE; s++) begin
          if (s < int'(n)) begin
            if (dig_q[r] == dig_q[s]) collide = 1'b1;
            if (dig_q[r] > dig_q[s]) parity = ~parity;
          end
        end
        if (carry) begin
          if (int'(dig_q[r]) == int'(n) - 1) begin
            dig_d[r] = '0;
          end else begin
            dig_d[r] = dig_q[r] + IdxW'(1);
            carry    = 1'b0;
          end
        end
      end
    end
  end

  assign rem_sh   = {rem_q, dq_q[DivSteps-1]};
  assign rem_diff = rem_sh - {1'b0, b_q};
  assign ge       = rem_sh >= {1'b0, b_q};
  assign sat      = |dq_q[DivSteps-1:SolW-1];
  assign qmag     = dq_q[SolW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q   <= '0;
      row_q <= '0;
      cnt_q <= '0;
      for (int r = 0; r < MAX_SIZE; r++) dig_q[r] <= '0;
    end else begin
      if (cmd_i.solve_start || cmd_i.den_save || cmd_i.det_next) begin
        for (int r = 0; r < MAX_SIZE; r++) dig_q[r] <= '0;
      end else if (cmd_i.tuple_next) begin
        dig_q <= dig_d;
      end
      if (cmd_i.solve_start) begin
        j_q <= '0;
      end else if (cmd_i.den_save || cmd_i.det_next) begin
        j_q <= j_q + SzW'(1);
      end
      if (cmd_i.prod_init) begin
        row_q <= '0;
      end else if (cmd_i.mul && (int'(row_q) != int'(n) - 1)) begin
        row_q <= row_q + IdxW'(1);
      end
      if (cmd_i.div_start) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.solve_start || cmd_i.den_save || cmd_i.det_next) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.den_save) den_q <= acc_q;
    if (cmd_i.prod_init) begin
      prod_q <= parity ? -SolW'(1) : SolW'(1);
    end else if (cmd_i.mul) begin
      prod_q <= SolW'(prod_q * SolW'($signed(rdata_q)));
    end
    if (cmd_i.div_start) begin
      b_q   <= abs64(den_q);
      rem_q <= '0;
      dq_q  <= {abs64(acc_q), FracBits'(0)};
      neg_q <= acc_q[SolW-1] ^ den_q[SolW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_diff[SolW-1:0] : rem_sh[SolW-1:0];
      dq_q  <= {dq_q[DivSteps-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_result || cmd_i.out_load_singular) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_singular) begin
      out_idx_q  <= '0;
      out_val_q  <= '0;
      out_sing_q <= 1'b1;
      out_last_q <= 1'b1;
    end else if (cmd_i.out_load_result) begin
      out_idx_q  <= OutIdxW'(j_q - SzW'(1));
      out_sing_q <= 1'b0;
      out_last_q <= (j_q == n);
      if (sat) begin
        out_val_q <= neg_q ? {1'b1, {(SolW-1){1'b0}}} : {1'b0, {(SolW-1){1'b1}}};
      end else begin
        out_val_q <= neg_q ? (SolW'(0) - qmag) : qmag;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(MTdataW - SolW - OutIdxW){1'b0}}, out_val_q, out_idx_q};
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_sing_q;

  assign sts_o.tuple_valid  = !collide;
  assign sts_o.tuple_last   = t_last;
  assign sts_o.row_last     = (int'(row_q) == int'(n) - 1);
  assign sts_o.acc_zero     = (acc_q == '0);
  assign sts_o.div_last     = (int'(cnt_q) == DivSteps - 1);
  assign sts_o.out_free     = !out_valid_q || m_tready_i;
  assign sts_o.unknown_last = (j_q == n);
  assign sts_o.first_det    = (j_q == '0);

  a_sing_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sing_q) |-> (out_last_q && out_val_q == '0 && out_idx_q == '0))
    else $error("singular beat malformed");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_tready_i) |=> $stable(out_val_q))
    else $error("output overwritten while stalled");
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_tready_i) |=> out_valid_q)
    else $error("result beat dropped while stalled");

endmodule

>>> hw/rtl/cls_controller.sv
// cls_controller: sequencing FSM for loading, determinant walks, division and
// result delivery. Depends on cls_pkg.
module cls_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tlast_i,
  output logic              s_tready_o,
  input  cls_pkg::cls_sts_t sts_i,
  output cls_pkg::cls_cmd_t cmd_o
);
  import cls_pkg::*;

  ctl_state_e state_q, state_d;
  logic       accept;

  assign accept = s_tvalid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && s_tlast_i) state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.tuple_valid ? ST_READ : ST_NEXT;
      ST_READ:  state_d = ST_MUL;
      ST_MUL:   state_d = sts_i.row_last ? ST_ACC : ST_READ;
      ST_ACC:   state_d = ST_NEXT;
      ST_NEXT:  state_d = sts_i.tuple_last ? ST_DONE : ST_CHECK;
      ST_DONE: begin
        if (!sts_i.first_det) begin
          state_d = ST_DIV;
        end else if (sts_i.acc_zero) begin
          state_d = ST_SING;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_DIV:   if (sts_i.div_last) state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.unknown_last ? ST_IDLE : ST_CHECK;
      end
      ST_SING:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o        = 1'b1;
        cmd_o.load        = accept;
        cmd_o.solve_start = accept && s_tlast_i;
      end
      ST_CHECK: cmd_o.prod_init = sts_i.tuple_valid;
      ST_READ:  cmd_o.rd_issue  = 1'b1;
      ST_MUL:   cmd_o.mul       = 1'b1;
      ST_ACC:   cmd_o.acc_add   = 1'b1;
      ST_NEXT:  cmd_o.tuple_next = !sts_i.tuple_last;
      ST_DONE: begin
        cmd_o.div_start = !sts_i.first_det;
        cmd_o.den_save  = sts_i.first_det && !sts_i.acc_zero;
      end
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_EMIT: begin
        cmd_o.out_load_result = sts_i.out_free;
        cmd_o.det_next        = sts_i.out_free && !sts_i.unknown_last;
      end
      ST_SING:  cmd_o.out_load_singular = sts_i.out_free;
      default: ;
    endcase
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load_result || cmd_o.out_load_singular) |-> sts_i.out_free)
    else $error("result loaded into a busy output");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_tlast_i) |=> (state_q == ST_CHECK))
    else $error("solve did not start");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sts_i.div_last) |=> (state_q == ST_DIV))
    else $error("division left early");

endmodule

>>> hw/rtl/cramer_linear_solver.sv
// Solves an n x n integer system (n = matrix_size, 2..MAX_SIZE) by Cramer's rule.
// Entries load one beat per cycle while idle; a beat with tlast stores its entry and
// starts the solve, during which s_axis_tready is low. Each determinant is an exact
// Leibniz sum: the controller walks all n^n column tuples, checking and stepping
// each, and each permutation among them adds n reads and multiplies (through the
// single store read port and the one multiplier), then one accumulate; a closing
// step ends the determinant. Each quotient is then formed in the bit-serial divider
// and loaded into the output register. Results (unknown index in tdata[1:0], value
// Q.16 in tdata[65:2], singular in tuser, last in tlast) may stall without losing
// data.
module cramer_linear_solver #(
  parameter int MAX_SIZE   = cls_pkg::MaxSizeDef,
  parameter int ENTRY_BITS = cls_pkg::EntryBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cls_pkg::CfgW-1:0]    cfg_data_i,    // matrix_size
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [cls_pkg::STdataW-1:0] s_axis_tdata,  // row_index, column_index, entry_value
  input  logic                        s_axis_tlast,  // start_solve
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cls_pkg::MTdataW-1:0] m_axis_tdata,  // unknown_index, solution_value
  output logic                        m_axis_tlast,  // last_result
  output logic                        m_axis_tuser   // singular
);
  import cls_pkg::*;

  cls_cmd_t cmd;
  cls_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cls_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cls_datapath #(
    .MAX_SIZE   (MAX_SIZE),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule
